// ----- hw/rtl/arpc_pkg.sv -----
`default_nettype none

package arpc_pkg;

  // Table geometry.
  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Field widths.
  localparam int OP_W   = 2;
  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int TIME_W = 32;
  localparam int TMO_W  = 12;
  localparam int CNT_W  = 7;

  localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(15);
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  // Request opcodes.
  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_TICK   = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;     // latch the accepted request and restart the scan
    logic issue;     // read the entry at the scan index and advance it
    logic load_out;  // move the finished result into the output register
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last;  // scan index points at the last entry
    logic out_free;   // output register is empty or being drained
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/arpc_ctrl.sv -----
`default_nettype none

module arpc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire arpc_pkg::dp_sts_t  sts,
  output arpc_pkg::ctrl_cmd_t     cmd
);
  import arpc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready    = (state_r == S_IDLE);
  assign cmd.start    = in_tvalid && in_tready;
  assign cmd.issue    = (state_r == S_SCAN);
  assign cmd.load_out = (state_r == S_FINISH) && sts.out_free;

  // The scan always ends on the last entry before draining.
  a_scan_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> ($past(state_r) == S_SCAN) && $past(sts.scan_last))
    else $error("drain entered without finishing the scan");

  // A new request is never taken while a scan is in flight.
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !cmd.start)
    else $error("request accepted during a scan");

endmodule

`default_nettype wire

// ----- hw/rtl/arpc_dp.sv -----
`default_nettype none

module arpc_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [arpc_pkg::OP_W-1:0]    in_cmd,
  input  wire logic [arpc_pkg::IP_W-1:0]    in_ip,
  input  wire logic [arpc_pkg::MAC_W-1:0]   in_mac,
  input  wire logic                         cfg_wr_en,
  input  wire logic [arpc_pkg::TMO_W-1:0]   cfg_wr_data,
  input  wire arpc_pkg::ctrl_cmd_t          cmd,
  output arpc_pkg::dp_sts_t                 sts,
  input  wire logic                         out_tready,
  output logic                              out_tvalid,
  output logic                              out_hit,
  output logic [arpc_pkg::MAC_W-1:0]        out_mac,
  output logic                              out_stored,
  output logic                              out_full,
  output logic [arpc_pkg::CNT_W-1:0]        out_expired
);
  import arpc_pkg::*;

  // Entry storage; contents are meaningful only where the valid bit is set.
  logic [IP_W-1:0]   ip_mem    [ENTRIES];
  logic [MAC_W-1:0]  mac_mem   [ENTRIES];
  logic [TIME_W-1:0] added_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  logic [TMO_W-1:0]  timeout_r;
  logic [TIME_W-1:0] now_r;

  // Latched request.
  op_t               op_r;
  logic [IP_W-1:0]   ip_q_r;
  logic [MAC_W-1:0]  mac_q_r;

  // Scan pipeline: issue stage reads memory, compare stage acts on it.
  logic [IDX_W-1:0]  idx_r;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic [IP_W-1:0]   rd_ip_r;
  logic [MAC_W-1:0]  rd_mac_r;
  logic [TIME_W-1:0] rd_added_r;

  // Accumulated result.
  logic              hit_r;
  logic [MAC_W-1:0]  mac_acc_r;
  logic              stored_r;
  logic [CNT_W-1:0]  exp_r;

  // Output register.
  logic              out_vld_r;
  logic              out_hit_r;
  logic [MAC_W-1:0]  out_mac_r;
  logic              out_stored_r;
  logic              out_full_r;
  logic [CNT_W-1:0]  out_exp_r;

  logic              cur_valid;
  logic [TIME_W-1:0] age;
  logic              lk_match;
  logic              ins_wr;
  logic              expire;

  assign cur_valid = valid_r[cmp_idx_r];
  assign age       = now_r - rd_added_r;
  assign lk_match  = cmp_vld_r && (op_r == OP_LOOKUP) && cur_valid && (rd_ip_r == ip_q_r);
  assign ins_wr    = cmp_vld_r && (op_r == OP_INSERT) && !cur_valid && !stored_r;
  assign expire    = cmp_vld_r && (op_r == OP_TICK) && cur_valid &&
                     (age > TIME_W'(timeout_r));

  assign sts.scan_last = (idx_r == IDX_W'(ENTRIES - 1));
  assign sts.out_free  = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_ip_r    <= ip_mem[idx_r];
      rd_mac_r   <= mac_mem[idx_r];
      rd_added_r <= added_mem[idx_r];
    end
    if (ins_wr) begin
      ip_mem[cmp_idx_r]    <= ip_q_r;
      mac_mem[cmp_idx_r]   <= mac_q_r;
      added_mem[cmp_idx_r] <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r    <= op_t'(in_cmd);
      ip_q_r  <= in_ip;
      mac_q_r <= in_mac;
    end
    cmp_idx_r <= idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      timeout_r  <= TMO_RESET;
      now_r      <= '0;
      idx_r      <= '0;
      cmp_vld_r  <= 1'b0;
      hit_r      <= 1'b0;
      mac_acc_r  <= '0;
      stored_r   <= 1'b0;
      exp_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      cmp_vld_r <= cmd.issue;
      if (cmd.start) begin
        idx_r     <= '0;
        hit_r     <= 1'b0;
        mac_acc_r <= '0;
        stored_r  <= 1'b0;
        exp_r     <= '0;
        if (op_t'(in_cmd) == OP_TICK) begin
          now_r <= now_r + TIME_W'(1);
        end
      end else if (cmd.issue) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (lk_match) begin
        hit_r     <= 1'b1;
        mac_acc_r <= rd_mac_r;
      end
      if (ins_wr) begin
        valid_r[cmp_idx_r] <= 1'b1;
        stored_r           <= 1'b1;
      end
      if (expire) begin
        valid_r[cmp_idx_r] <= 1'b0;
        if (exp_r != CNT_MAX) begin
          exp_r <= exp_r + CNT_W'(1);
        end
      end
      if (cmd.load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_hit_r    <= hit_r;
      out_mac_r    <= mac_acc_r;
      out_stored_r <= stored_r;
      out_full_r   <= (op_r == OP_INSERT) && !stored_r;
      out_exp_r    <= exp_r;
    end
  end

  assign out_tvalid  = out_vld_r;
  assign out_hit     = out_hit_r;
  assign out_mac     = out_mac_r;
  assign out_stored  = out_stored_r;
  assign out_full    = out_full_r;
  assign out_expired = out_exp_r;

  // An insert is either stored or reported full, never both.
  a_ins_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.load_out) |-> !(out_stored_r && out_full_r))
    else $error("insert both stored and flagged full");

  // Lookup fields stay zero for any request other than a lookup.
  a_hit_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && (op_r != OP_LOOKUP)) |=> !out_hit_r && (out_mac_r == '0))
    else $error("lookup result on a non-lookup request");

  // The compare stage only acts on an entry read in the previous cycle.
  a_cmp_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> $past(cmd.issue))
    else $error("compare stage without a memory read");

  // At most one slot is filled per insert.
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    ins_wr |=> !ins_wr)
    else $error("insert wrote more than one slot");

endmodule

`default_nettype wire

// ----- hw/rtl/arp_cache_table_top.sv -----
`default_nettype none

// ARP cache table: 64 slots mapping IPv4 addresses to 48-bit MAC addresses.
// Each request carries an opcode in in_tuser (lookup, insert or one-second
// tick) and produces exactly one result. A lookup reports the MAC of the
// highest-numbered valid slot whose address matches; an insert fills the
// lowest-numbered free slot, stamping it with the current second count, and
// sets table_full when no slot is free (duplicates are not checked); a tick
// advances the second count and invalidates every slot older than the
// timeout register, reporting how many were removed. The unused opcode
// returns an all-zero result. Every request walks the whole table through
// one memory read port, one slot per cycle; each slot read is compared in
// the next stage, the last compare completes in a drain state, and the
// result waits until the output register is free and is then loaded. A new
// request is accepted in the cycle after its predecessor's result has been
// loaded, even if that result has not yet been taken. The valid bits clear
// on reset with no sweep, so the block is ready immediately. The timeout
// register is written through cfg_wr_en and cfg_wr_data and should only be
// changed while no request is in flight.
module arp_cache_table_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // [31:0] ip, [79:32] mac
  input  wire logic [1:0]  in_tuser,   // [1:0] cmd
  // Configuration: timeout in seconds.
  input  wire logic        cfg_wr_en,
  input  wire logic [11:0] cfg_wr_data,
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata   // [0] hit, [48:1] mac_out, [49] stored,
                                       // [50] table_full, [57:51] expired_count,
                                       // [63:58] zero
);
  import arpc_pkg::*;

  ctrl_cmd_t         cmd;
  dp_sts_t           sts;
  logic              res_hit;
  logic [MAC_W-1:0]  res_mac;
  logic              res_stored;
  logic              res_full;
  logic [CNT_W-1:0]  res_expired;

  // Sequencing of each request through the table scan.
  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Entry memories, valid bits, second counter and result registers.
  arpc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_cmd      (in_tuser),
    .in_ip       (in_tdata[31:0]),
    .in_mac      (in_tdata[79:32]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_hit     (res_hit),
    .out_mac     (res_mac),
    .out_stored  (res_stored),
    .out_full    (res_full),
    .out_expired (res_expired)
  );

  // Results are packed from the low bit up; the top six bits are padded with zeros.
  assign out_tdata = {6'd0, res_expired, res_full, res_stored, res_mac, res_hit};

endmodule

`default_nettype wire
